// ===== sv/cdc_pkg.sv =====
// Shared types, constants and calendar helpers for the date calculator.
// Used by cdc_year_unit, cdc_next_date and calendar_date_calculator_top.
package cdc_pkg;

  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int DN_W    = 23;
  localparam int DIFF_W  = 22;
  localparam int ORD_W   = 2;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 56;

  localparam logic [DN_W-1:0] DIFF_MAX = DN_W'(4194303);

  // floor(t / 25) = (t * RECIP_25) >> RECIP_SHIFT for t below 4200
  localparam logic [10:0] RECIP_25    = 11'd1311;
  localparam int          RECIP_SHIFT = 15;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_MAR = 4'd3;
  localparam logic [MON_W-1:0] MON_JUL = 4'd7;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  typedef enum logic [ORD_W-1:0] {
    ORD_EQUAL   = 2'd0,
    ORD_LATER   = 2'd1,
    ORD_EARLIER = 2'd2
  } order_t;

  // Days before each month code in a common year; codes 13..15 continue the pattern.
  localparam logic [8:0] BEFORE_MONTH [16] = '{
    9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd395, 9'd426
  };

  typedef struct packed {
    logic s1;
    logic s2;
  } pipe_en_t;

  typedef struct packed {
    logic              valid;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } next_date_t;

  typedef struct packed {
    logic              first_valid;
    logic              first_leap;
    order_t            order;
    logic [DIFF_W-1:0] day_difference;
    logic [DAY_W-1:0]  next_day;
    logic [MON_W-1:0]  next_month;
    logic [YEAR_W-1:0] next_year;
  } result_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m == MON_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m <= MON_JUL) begin
      len = m[0] ? 5'd31 : 5'd30;
    end else begin
      len = m[0] ? 5'd30 : 5'd31;
    end
    return len;
  endfunction

endpackage

// ===== sv/cdc_year_unit.sv =====
// Two-stage year arithmetic: days before Jan 1 of the year and the leap flag.
// Depends on cdc_pkg.
module cdc_year_unit
  import cdc_pkg::*;
(
  input  logic              clk,
  input  pipe_en_t          en,
  input  logic [YEAR_W-1:0] year,
  output logic [DN_W-1:0]   base,
  output logic              leap
);

  logic [14:0] y_p3, y_p99, y_p399;
  logic [23:0] p100c;
  logic [21:0] p400c;
  logic [22:0] p100f;
  logic [20:0] p400f;

  logic [YEAR_W-1:0] y_r;
  logic [DN_W-1:0]   y365_r;
  logic [12:0]       ceil4_r;
  logic [8:0]        q100c_r;
  logic [6:0]        q400c_r;
  logic [7:0]        q100f_r;
  logic [5:0]        q400f_r;

  logic [12:0]       m100;
  logic [10:0]       m400;
  logic              leap_nxt;
  logic [DN_W-1:0]   base_nxt;
  logic [DN_W-1:0]   base_r;
  logic              leap_r;

  assign y_p3   = {1'b0, year} + 15'd3;
  assign y_p99  = {1'b0, year} + 15'd99;
  assign y_p399 = {1'b0, year} + 15'd399;
  assign p100c  = 24'(y_p99[14:2]) * 24'(RECIP_25);
  assign p400c  = 22'(y_p399[14:4]) * 22'(RECIP_25);
  assign p100f  = 23'(year[13:2]) * 23'(RECIP_25);
  assign p400f  = 21'(year[13:4]) * 21'(RECIP_25);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      y_r     <= year;
      y365_r  <= DN_W'(year) * DN_W'(365);
      ceil4_r <= y_p3[14:2];
      q100c_r <= p100c[23:RECIP_SHIFT];
      q400c_r <= p400c[21:RECIP_SHIFT];
      q100f_r <= p100f[22:RECIP_SHIFT];
      q400f_r <= p400f[20:RECIP_SHIFT];
    end
  end

  assign m100 = 13'(q100f_r) * 13'(25);
  assign m400 = 11'(q400f_r) * 11'(25);

  assign leap_nxt = (y_r[1:0] == 2'b00) &&
                    ((13'(y_r[13:2]) != m100) ||
                     ((y_r[3:0] == 4'b0000) && (11'(y_r[13:4]) == m400)));
  assign base_nxt = y365_r + DN_W'(ceil4_r) + DN_W'(q400c_r) - DN_W'(q100c_r);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      base_r <= base_nxt;
      leap_r <= leap_nxt;
    end
  end

  assign base = base_r;
  assign leap = leap_r;

endmodule

// ===== sv/cdc_next_date.sv =====
// Validity check and next-date increment for one calendar date.
// Depends on cdc_pkg.
module cdc_next_date
  import cdc_pkg::*;
(
  input  logic [DAY_W-1:0]  day,
  input  logic [MON_W-1:0]  month,
  input  logic [YEAR_W-1:0] year,
  input  logic              leap,
  output next_date_t        nxt
);

  logic [DAY_W-1:0] len;
  logic             valid;

  assign len   = month_len(month, leap);
  assign valid = (month >= MON_JAN) && (month <= MON_DEC) &&
                 (day != '0) && (day <= len);

  always_comb begin
    nxt.valid = valid;
    nxt.day   = day;
    nxt.month = month;
    nxt.year  = year;
    if (valid) begin
      if (day == len) begin
        nxt.day = DAY_W'(1);
        if (month == MON_DEC) begin
          nxt.month = MON_JAN;
          nxt.year  = year + YEAR_W'(1);
        end else begin
          nxt.month = month + MON_W'(1);
        end
      end else begin
        nxt.day = day + DAY_W'(1);
      end
    end
  end

endmodule

// ===== sv/calendar_date_calculator_top.sv =====
// Top level of the Gregorian date calculator: four-stage pipeline.
// Depends on cdc_pkg, cdc_year_unit and cdc_next_date.
//
// Usage:
//   Input channel in_*: one pair of dates per item. Result channel out_*:
//   one result item per input item, in order.
//   Stage 1 registers the year products (x365 and reciprocal multiplies by
//   1/25), stage 2 forms days before Jan 1 and the leap flag, stage 3 adds
//   month and day offsets and builds the next date, stage 4 forms the
//   saturated absolute difference and is the output register.
//   Latency: an accepted item moves through stages 1 to 4 in order, and
//   out_tvalid rises once it sits in the output register. Throughput: one
//   item per cycle while out_tready is high; the critical path is a 15-bit
//   add into a 13x11 multiply, or a short chain of 23-bit adds and compares.
//   Reset: rst_n low empties the pipeline; out_tvalid drops, in_tready rises.
//   Stall: when out_tready is low the result holds in the output register;
//   each stage keeps taking items while an empty slot lies ahead of it, so
//   in_tready falls only when all four stages hold items.
module calendar_date_calculator_top
  import cdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // first_day, first_month, first_year, second_day, second_month, second_year
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // first_valid, first_leap, order, day_difference, next_day, next_month, next_year
  output logic [OUT_W-1:0] out_tdata
);

  logic [DAY_W-1:0]  d1_in, d2_in;
  logic [MON_W-1:0]  m1_in, m2_in;
  logic [YEAR_W-1:0] y1_in, y2_in;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  pipe_en_t en;

  logic [DAY_W-1:0]  d1_s1_r, d2_s1_r, d1_s2_r, d2_s2_r;
  logic [MON_W-1:0]  m1_s1_r, m2_s1_r, m1_s2_r, m2_s2_r;
  logic [YEAR_W-1:0] y1_s1_r, y1_s2_r;
  order_t            ord_nxt, ord_s1_r, ord_s2_r, ord_s3_r;

  logic [DN_W-1:0]   base1, base2;
  logic              leap1, leap2;
  logic [DN_W-1:0]   n1_nxt, n2_nxt, n1_r, n2_r;
  next_date_t        nd_nxt, nd_r;
  logic              leap1_s3_r;

  logic [DN_W-1:0]   diff_raw;
  result_t           res_nxt, res_r;

  assign d1_in = in_tdata[4:0];
  assign m1_in = in_tdata[8:5];
  assign y1_in = in_tdata[22:9];
  assign d2_in = in_tdata[27:23];
  assign m2_in = in_tdata[31:28];
  assign y2_in = in_tdata[45:32];

  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign en.s1 = rdy1;
  assign en.s2 = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_comb begin
    if ({y1_in, m1_in, d1_in} > {y2_in, m2_in, d2_in}) begin
      ord_nxt = ORD_LATER;
    end else if ({y1_in, m1_in, d1_in} < {y2_in, m2_in, d2_in}) begin
      ord_nxt = ORD_EARLIER;
    end else begin
      ord_nxt = ORD_EQUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      d1_s1_r  <= d1_in;
      m1_s1_r  <= m1_in;
      y1_s1_r  <= y1_in;
      d2_s1_r  <= d2_in;
      m2_s1_r  <= m2_in;
      ord_s1_r <= ord_nxt;
    end
    if (rdy2) begin
      d1_s2_r  <= d1_s1_r;
      m1_s2_r  <= m1_s1_r;
      y1_s2_r  <= y1_s1_r;
      d2_s2_r  <= d2_s1_r;
      m2_s2_r  <= m2_s1_r;
      ord_s2_r <= ord_s1_r;
    end
  end

  cdc_year_unit u_year1 (
    .clk  (clk),
    .en   (en),
    .year (y1_in),
    .base (base1),
    .leap (leap1)
  );

  cdc_year_unit u_year2 (
    .clk  (clk),
    .en   (en),
    .year (y2_in),
    .base (base2),
    .leap (leap2)
  );

  assign n1_nxt = base1 + DN_W'(BEFORE_MONTH[m1_s2_r]) +
                  DN_W'((m1_s2_r >= MON_MAR) && leap1) + DN_W'(d1_s2_r);
  assign n2_nxt = base2 + DN_W'(BEFORE_MONTH[m2_s2_r]) +
                  DN_W'((m2_s2_r >= MON_MAR) && leap2) + DN_W'(d2_s2_r);

  cdc_next_date u_next (
    .day   (d1_s2_r),
    .month (m1_s2_r),
    .year  (y1_s2_r),
    .leap  (leap1),
    .nxt   (nd_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy3) begin
      n1_r       <= n1_nxt;
      n2_r       <= n2_nxt;
      nd_r       <= nd_nxt;
      leap1_s3_r <= leap1;
      ord_s3_r   <= ord_s2_r;
    end
  end

  assign diff_raw = (n1_r > n2_r) ? (n1_r - n2_r) : (n2_r - n1_r);

  always_comb begin
    res_nxt.first_valid    = nd_r.valid;
    res_nxt.first_leap     = leap1_s3_r;
    res_nxt.order          = ord_s3_r;
    res_nxt.day_difference = (diff_raw > DIFF_MAX) ? DIFF_MAX[DIFF_W-1:0]
                                                   : diff_raw[DIFF_W-1:0];
    res_nxt.next_day       = nd_r.day;
    res_nxt.next_month     = nd_r.month;
    res_nxt.next_year      = nd_r.year;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {7'b0, res_r.next_year, res_r.next_month, res_r.next_day,
                       res_r.day_difference, res_r.order, res_r.first_leap,
                       res_r.first_valid};

  a_equal_zero_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.order == ORD_EQUAL) |-> (res_r.day_difference == '0))
    else $error("equal dates with nonzero difference");

  a_next_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.first_valid) |->
      (res_r.next_day != '0 && res_r.next_month >= MON_JAN &&
       res_r.next_month <= MON_DEC))
    else $error("next date out of range for valid date");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && v4_r && !out_tready))
    else $error("input stalled with a free pipeline slot");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(res_r)))
    else $error("stalled result changed");

endmodule
